// ===== rtl/dsoc_pkg.sv =====
// ----------------------------------------------------------------------------
// dsoc_pkg: shared constants and types of the duplicate and order checker
// Sizes of the value store, the counters and the queue between the front
// and back parts, plus the item record that travels through that queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dsoc_pkg;

	// Number of values kept per sequence.
	localparam int DEPTH = 256;

	localparam int VALUE_W = 32;
	localparam int ELEM_COUNT_W = 9;

	// Store address and counter widths follow from DEPTH. The counter must hold
	// DEPTH itself and is never narrower than the reported count.
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COUNT_RAW_W = $clog2(DEPTH + 1);
	localparam int COUNT_W = (COUNT_RAW_W > ELEM_COUNT_W) ? COUNT_RAW_W : ELEM_COUNT_W;

	localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(DEPTH);
	localparam logic [ELEM_COUNT_W-1:0] DEPTH_ELEM = DEPTH_COUNT[ELEM_COUNT_W-1:0];

	// Queue between front and back; a power of two.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	// One classified item. lower/higher compare against the predecessor and
	// are both clear on the first element of a sequence.
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
		logic                      lower;
		logic                      higher;
	} item_t;

endpackage

`default_nettype wire

// ===== rtl/dsoc_if.sv =====
// ----------------------------------------------------------------------------
// dsoc_if: channel interfaces of the duplicate and order checker
// Valid/ready channels for incoming values and for sequence results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsoc_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [dsoc_pkg::VALUE_W-1:0] value;
	logic                                last;

	modport source(output valid, output value, output last, input ready);
	modport sink(input valid, input value, input last, output ready);
endinterface

interface dsoc_out_if;
	logic                                valid;
	logic                                ready;
	logic                                has_duplicate;
	logic                                is_ascending;
	logic                                is_descending;
	logic [dsoc_pkg::ELEM_COUNT_W-1:0]   element_count;
	logic                                overflowed;

	modport source(output valid, output has_duplicate, output is_ascending,
		output is_descending, output element_count, output overflowed, input ready);
	modport sink(input valid, input has_duplicate, input is_ascending,
		input is_descending, input element_count, input overflowed, output ready);
endinterface

`default_nettype wire

// ===== rtl/sequence_duplicate_and_order_check.sv =====
// ----------------------------------------------------------------------------
// sequence_duplicate_and_order_check: duplicate and sortedness checker
// Checks a marked sequence of signed 32-bit values for repeated values and
// for non-strict ascending or descending order, and reports once per sequence.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                                     Transaction
//   items     in         value[31:0] signed, last                    one element
//   results   out        has_duplicate, is_ascending, is_descending, one sequence
//                        element_count[8:0], overflowed
//
// For each element the back part reads back the n values already stored in
// the sequence (at most DEPTH) through the single read port of the value
// store, one entry per cycle.
// Reset is asynchronous and clears all control state at once; the store
// needs no clearing pass since only entries already written are read.
// A two-entry queue lets the input side keep accepting while the store is
// scanned, and the result register lets the next sequence proceed while a
// result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sequence_duplicate_and_order_check (
	input  logic       clk,
	input  logic       arst_n,
	dsoc_in_if.sink    items,
	dsoc_out_if.source results
);

	// Front to queue.
	logic            q_push_valid;
	logic            q_push_ready;
	dsoc_pkg::item_t q_push_item;

	// Queue to back.
	logic            q_pop_valid;
	logic            q_pop_ready;
	dsoc_pkg::item_t q_pop_item;

	// The front tags each element with how it relates to its predecessor.
	dsoc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.push_valid(q_push_valid),
		.push_ready(q_push_ready),
		.push_item (q_push_item)
	);

	dsoc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(q_push_valid),
		.push_ready(q_push_ready),
		.push_item (q_push_item),
		.pop_valid (q_pop_valid),
		.pop_ready (q_pop_ready),
		.pop_item  (q_pop_item)
	);

	// The back scans the store, appends the value and owns all sequence flags.
	dsoc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(q_pop_valid),
		.pop_ready(q_pop_ready),
		.pop_item (q_pop_item),
		.results  (results)
	);

	// An overflowed sequence has filled the whole store.
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.overflowed |->
			results.element_count == dsoc_pkg::DEPTH_ELEM)
		else $error("overflow reported with a partly filled store");

	// A single element is trivially ordered both ways and unique.
	a_single_elem: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.overflowed && results.element_count == 9'd1 |->
			results.is_ascending && results.is_descending && !results.has_duplicate)
		else $error("single-element sequence reported wrongly");

	// Ascending and descending at once means all values are equal.
	a_flat_dup: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.overflowed && results.element_count > 9'd1 &&
			results.is_ascending && results.is_descending |-> results.has_duplicate)
		else $error("constant sequence without a duplicate");

endmodule

`default_nettype wire

// ===== rtl/dsoc_ram.sv =====
// ----------------------------------------------------------------------------
// dsoc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dsoc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dsoc_front.sv =====
// ----------------------------------------------------------------------------
// dsoc_front: input side of the duplicate and order checker
// Accepts values and tags each with its order relation to its predecessor.
// ----------------------------------------------------------------------------
`default_nettype none

module dsoc_front (
	input  logic            clk,
	input  logic            arst_n,
	dsoc_in_if.sink         items,
	output logic            push_valid,
	input  logic            push_ready,
	output dsoc_pkg::item_t push_item
);

	logic                                first_q;
	logic signed [dsoc_pkg::VALUE_W-1:0] prev_q;
	logic                                accept;

	assign items.ready = push_ready;
	assign push_valid  = items.valid;
	assign accept      = items.valid && push_ready;

	always_comb begin
		push_item.value  = items.value;
		push_item.last   = items.last;
		push_item.lower  = !first_q && (items.value < prev_q);
		push_item.higher = !first_q && (items.value > prev_q);
	end

	// The element after a last mark opens a new sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (accept) begin
			first_q <= items.last;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_q <= items.value;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dsoc_queue.sv =====
// ----------------------------------------------------------------------------
// dsoc_queue: short item queue between front and back
// Register-based FIFO that lets the two sides stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module dsoc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  dsoc_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output dsoc_pkg::item_t pop_item
);

	dsoc_pkg::item_t               mem_q [dsoc_pkg::QUEUE_DEPTH];
	logic [dsoc_pkg::QPTR_W:0]     wr_ptr_q;
	logic [dsoc_pkg::QPTR_W:0]     rd_ptr_q;
	logic                          full;
	logic                          empty;

	assign empty = (wr_ptr_q == rd_ptr_q);
	assign full  = (wr_ptr_q[dsoc_pkg::QPTR_W] != rd_ptr_q[dsoc_pkg::QPTR_W]) &&
		(wr_ptr_q[dsoc_pkg::QPTR_W-1:0] == rd_ptr_q[dsoc_pkg::QPTR_W-1:0]);

	assign push_ready = !full;
	assign pop_valid  = !empty;
	assign pop_item   = mem_q[rd_ptr_q[dsoc_pkg::QPTR_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push_valid && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_ready && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && !full) begin
			mem_q[wr_ptr_q[dsoc_pkg::QPTR_W-1:0]] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dsoc_back.sv =====
// ----------------------------------------------------------------------------
// dsoc_back: execution side of the duplicate and order checker
// Scans the value store for a match, appends the value, keeps the running
// flags and presents the result of each sequence in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsoc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  dsoc_pkg::item_t pop_item,
	dsoc_out_if.source      results
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                        state_q;
	dsoc_pkg::item_t                   cur_q;
	logic [dsoc_pkg::COUNT_W-1:0]      count_q;
	logic [dsoc_pkg::COUNT_W-1:0]      rd_cnt_q;
	logic                              rd_pend_q;
	logic                              dup_q;
	logic                              asc_q;
	logic                              desc_q;
	logic                              ovf_q;

	logic                              out_valid_q;
	logic                              out_dup_q;
	logic                              out_asc_q;
	logic                              out_desc_q;
	logic [dsoc_pkg::ELEM_COUNT_W-1:0] out_count_q;
	logic                              out_ovf_q;

	logic                              rd_issue;
	logic [dsoc_pkg::VALUE_W-1:0]      rd_data;
	logic                              hit;
	logic                              out_free;
	logic                              finish;
	logic                              has_room;
	logic                              we;
	logic                              asc_next;
	logic                              desc_next;
	logic                              ovf_next;
	logic [dsoc_pkg::COUNT_W-1:0]      count_next;

	assign pop_ready = (state_q == ST_IDLE);
	assign rd_issue  = (state_q == ST_SCAN) && (rd_cnt_q != count_q);
	assign hit       = rd_pend_q && (rd_data == $unsigned(cur_q.value));
	assign out_free  = !out_valid_q || results.ready;
	assign finish    = (state_q == ST_DONE) && (!cur_q.last || out_free);
	assign has_room  = (count_q != dsoc_pkg::DEPTH_COUNT);
	assign we        = finish && has_room;

	assign asc_next   = asc_q & ~cur_q.lower;
	assign desc_next  = desc_q & ~cur_q.higher;
	assign ovf_next   = ovf_q | ~has_room;
	assign count_next = has_room ? count_q + 1'b1 : count_q;

	dsoc_ram #(
		.WIDTH(dsoc_pkg::VALUE_W),
		.DEPTH(dsoc_pkg::DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(count_q[dsoc_pkg::ADDR_W-1:0]),
		.wdata($unsigned(cur_q.value)),
		.re   (rd_issue),
		.raddr(rd_cnt_q[dsoc_pkg::ADDR_W-1:0]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_cnt_q    <= '0;
			rd_pend_q   <= 1'b0;
			dup_q       <= 1'b0;
			asc_q       <= 1'b1;
			desc_q      <= 1'b1;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish && cur_q.last) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						rd_cnt_q  <= '0;
						rd_pend_q <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// The read issued last cycle is compared in this one, also
					// in the cycle that leaves the scan.
					rd_pend_q <= rd_issue;
					if (rd_issue) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end else begin
						state_q <= ST_DONE;
					end
					if (hit) begin
						dup_q <= 1'b1;
					end
				end
				ST_DONE: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if (cur_q.last) begin
							count_q <= '0;
							dup_q   <= 1'b0;
							asc_q   <= 1'b1;
							desc_q  <= 1'b1;
							ovf_q   <= 1'b0;
						end else begin
							count_q <= count_next;
							asc_q   <= asc_next;
							desc_q  <= desc_next;
							ovf_q   <= ovf_next;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			cur_q <= pop_item;
		end
		if (finish && cur_q.last) begin
			out_dup_q   <= dup_q;
			out_asc_q   <= asc_next;
			out_desc_q  <= desc_next;
			out_count_q <= count_next[dsoc_pkg::ELEM_COUNT_W-1:0];
			out_ovf_q   <= ovf_next;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.has_duplicate = out_dup_q;
	assign results.is_ascending  = out_asc_q;
	assign results.is_descending = out_desc_q;
	assign results.element_count = out_count_q;
	assign results.overflowed    = out_ovf_q;

endmodule

`default_nettype wire
